// ===== hw/rtl/tpes_pkg.sv =====
// Shared types and constants for the tween phase event sequencer.
// Holds the configuration record, the event codes and the front-to-back queue entry.
// No dependencies.
package tpes_pkg;

    localparam int unsigned FRAC_BITS_DEFAULT = 16;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned NUM_SLOTS         = 6;
    localparam int unsigned CFG_INDEX_W       = 3;

    // Event codes as they appear on the result channel.
    typedef enum logic [1:0] {
        EV_UPDATE   = 2'd0,
        EV_START    = 2'd1,
        EV_LOOP     = 2'd2,
        EV_COMPLETE = 2'd3
    } ev_kind_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_START_TIME   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_DURATION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_MODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_PONG    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INFINITE     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ABSOLUTE     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_REMOVED      = 3'd7;

    // Event slots of one request, in the order they are delivered.
    localparam int unsigned SLOT_INIT_LOOP = 0;
    localparam int unsigned SLOT_START     = 1;
    localparam int unsigned SLOT_LOOP      = 2;
    localparam int unsigned SLOT_UPDATE    = 3;
    localparam int unsigned SLOT_REV_START = 4;
    localparam int unsigned SLOT_COMPLETE  = 5;

    typedef struct packed {
        logic [31:0] start_time;
        logic [30:0] duration;
        logic [31:0] inv_duration;
        logic        loop_mode;
        logic        ping_pong_mode;
        logic        infinite_mode;
        logic        absolute_time;
        logic        removed;
    } cfg_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic [31:0]          upd_time;
        logic                 cmp_rev;
    } q_entry_t;

    typedef struct packed {
        logic        has_started;
        logic        has_rev_started;
        logic        is_complete;
        logic        is_rev_complete;
        logic [31:0] last_iter;
    } trk_state_t;

endpackage

// ===== hw/rtl/tpes_front.sv =====
// Front part of the tween phase event sequencer: accepts time steps, forms the phase
// and decides which events each request causes, tracking the started and completed flags.
// Depends on tpes_pkg.
module tpes_front #(
    parameter int unsigned FRAC_BITS = tpes_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tpes_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        in_now,
    input  logic               in_rev,
    input  logic               q_full,
    output logic               q_push,
    output tpes_pkg::q_entry_t q_entry
);
    import tpes_pkg::*;

    localparam int unsigned PW = 64 - FRAC_BITS;
    localparam logic [FRAC_BITS:0]   ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+1:0] TWO   = {1'b1, {(FRAC_BITS + 1){1'b0}}};
    localparam logic [31:0]          ONE32 = 32'd1 << FRAC_BITS;

    logic        advance;
    logic [32:0] diff_w;
    logic [31:0] abs_sat_w;
    logic [32:0] end_w;
    logic        lt_end_w;
    logic [63:0] prod_w;

    logic        v1_reg;
    logic [31:0] now1_reg;
    logic        rev1_reg;
    logic        ge1_reg;
    logic [31:0] abs1_reg;
    logic [31:0] abs_sat1_reg;

    logic        v2_reg;
    logic        rev2_reg;
    logic        ge2_reg;
    logic [31:0] abs_sat2_reg;
    logic [63:0] prod2_reg;
    logic        lt_end2_reg;

    logic [PW-1:0]          phase;
    logic [FRAC_BITS+1:0]   two_minus;
    logic [FRAC_BITS:0]     rel;
    logic [31:0]            upd_time;
    logic [63:0]            iter_wide;
    logic [31:0]            iter;

    trk_state_t             state_reg;
    trk_state_t             state_next;
    logic [NUM_SLOTS-1:0]   slots;
    logic [31:0]            ev_time;
    logic                   cmp_rev;

    assign advance  = !v2_reg || !q_full;
    assign in_ready = advance;

    assign diff_w    = {in_now[31], in_now} - {cfg.start_time[31], cfg.start_time};
    assign abs_sat_w = (!diff_w[32] && diff_w[31]) ? 32'h7FFF_FFFF : diff_w[31:0];

    assign end_w    = {cfg.start_time[31], cfg.start_time} + {2'b00, cfg.duration};
    assign lt_end_w = $signed({now1_reg[31], now1_reg}) < $signed(end_w);
    assign prod_w   = abs1_reg * cfg.inv_duration;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            now1_reg     <= in_now;
            rev1_reg     <= in_rev;
            ge1_reg      <= !diff_w[32];
            abs1_reg     <= diff_w[31:0];
            abs_sat1_reg <= abs_sat_w;
            rev2_reg     <= rev1_reg;
            ge2_reg      <= ge1_reg;
            abs_sat2_reg <= abs_sat1_reg;
            prod2_reg    <= prod_w;
            lt_end2_reg  <= lt_end_w;
        end
    end

    always_comb begin
        phase     = prod2_reg[63:FRAC_BITS];
        two_minus = TWO - {1'b0, phase[FRAC_BITS:0]};
        if (cfg.ping_pong_mode) begin
            rel = (phase[FRAC_BITS:0] > ONE) ? two_minus[FRAC_BITS:0] : phase[FRAC_BITS:0];
        end else if (cfg.loop_mode) begin
            rel = {1'b0, phase[FRAC_BITS-1:0]};
        end else begin
            rel = (|phase[PW-1:FRAC_BITS]) ? ONE : {1'b0, phase[FRAC_BITS-1:0]};
        end
        if (cfg.absolute_time) begin
            upd_time = abs_sat2_reg;
        end else if (cfg.inv_duration == 32'd0) begin
            upd_time = ONE32;
        end else begin
            upd_time = {{(31 - FRAC_BITS){1'b0}}, rel};
        end
        iter_wide = prod2_reg >> (2 * FRAC_BITS);
        iter      = (|iter_wide[63:31]) ? 32'h7FFF_FFFF : {1'b0, iter_wide[30:0]};
    end

    always_comb begin
        state_next = state_reg;
        slots      = '0;
        ev_time    = '0;
        cmp_rev    = 1'b0;
        if (v2_reg && !cfg.removed) begin
            if (!state_reg.has_rev_started && rev2_reg && !ge2_reg) begin
                slots[SLOT_UPDATE]         = 1'b1;
                slots[SLOT_REV_START]      = 1'b1;
                ev_time                    = cfg.absolute_time ? cfg.start_time : 32'd0;
                state_next.has_rev_started = 1'b1;
                state_next.has_started     = 1'b0;
            end else if (ge2_reg) begin
                if (!state_reg.has_started && !rev2_reg) begin
                    slots[SLOT_INIT_LOOP]      = 1'b1;
                    slots[SLOT_START]          = 1'b1;
                    state_next.has_started     = 1'b1;
                    state_next.has_rev_started = 1'b0;
                    state_next.last_iter       = '0;
                end
                if ((cfg.loop_mode || cfg.ping_pong_mode) && iter != state_next.last_iter) begin
                    slots[SLOT_LOOP]     = 1'b1;
                    state_next.last_iter = iter;
                end
                slots[SLOT_UPDATE] = 1'b1;
                ev_time            = upd_time;
            end
            if (lt_end2_reg) begin
                if (!state_reg.is_rev_complete && rev2_reg) begin
                    slots[SLOT_COMPLETE]       = 1'b1;
                    cmp_rev                    = 1'b1;
                    state_next.is_rev_complete = 1'b1;
                    state_next.is_complete     = 1'b0;
                end
            end else if (!cfg.loop_mode && !cfg.infinite_mode) begin
                if (!state_reg.is_complete && !rev2_reg) begin
                    slots[SLOT_COMPLETE]       = 1'b1;
                    state_next.is_complete     = 1'b1;
                    state_next.is_rev_complete = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.has_started     <= 1'b0;
            state_reg.has_rev_started <= 1'b0;
            state_reg.is_complete     <= 1'b0;
            state_reg.is_rev_complete <= 1'b0;
            state_reg.last_iter       <= '1;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign q_push           = v2_reg && !q_full && (|slots);
    assign q_entry.slots    = slots;
    assign q_entry.upd_time = ev_time;
    assign q_entry.cmp_rev  = cmp_rev;

endmodule

// ===== hw/rtl/tpes_queue.sv =====
// Short request queue between the front and back parts of the sequencer.
// Register-based FIFO of event bundles; depends on tpes_pkg.
module tpes_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tpes_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output tpes_pkg::q_entry_t head
);
    import tpes_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/tpes_back.sv =====
// Back part of the tween phase event sequencer; depends on tpes_pkg. Unpacks each queued
// bundle into events for the registered result channel, one per cycle unless stalled.
module tpes_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  tpes_pkg::q_entry_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tpes_pkg::ev_kind_t out_kind,
    output logic               out_rev,
    output logic [31:0]        out_time,
    output logic               out_last
);
    import tpes_pkg::*;

    logic [NUM_SLOTS-1:0] slots_reg;
    logic [NUM_SLOTS-1:0] slots_next;
    logic [31:0]          time_reg;
    logic                 crev_reg;
    logic                 valid_reg;
    logic                 valid_next;
    ev_kind_t             kind_reg;
    logic                 rev_reg;
    logic [31:0]          otime_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 emit;
    logic                 load;
    logic [NUM_SLOTS-1:0] remain;
    ev_kind_t             sel_kind;
    logic                 sel_rev;
    logic [31:0]          sel_time;

    assign out_free = !valid_reg || out_ready;
    assign emit     = out_free && (slots_reg != '0);
    assign remain   = emit ? (slots_reg & (slots_reg - NUM_SLOTS'(1))) : slots_reg;
    assign load     = (remain == '0) && q_not_empty;
    assign q_pop    = load;

    always_comb begin
        sel_time = '0;
        sel_rev  = 1'b0;
        sel_kind = EV_UPDATE;
        priority if (slots_reg[SLOT_INIT_LOOP]) begin
            sel_kind = EV_LOOP;
        end else if (slots_reg[SLOT_START]) begin
            sel_kind = EV_START;
        end else if (slots_reg[SLOT_LOOP]) begin
            sel_kind = EV_LOOP;
        end else if (slots_reg[SLOT_UPDATE]) begin
            sel_kind = EV_UPDATE;
            sel_time = time_reg;
        end else if (slots_reg[SLOT_REV_START]) begin
            sel_kind = EV_START;
            sel_rev  = 1'b1;
        end else begin
            sel_kind = EV_COMPLETE;
            sel_rev  = crev_reg;
        end
        slots_next = load ? q_head.slots : remain;
        if (emit) begin
            valid_next = 1'b1;
        end else if (out_free) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            slots_reg <= slots_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            time_reg <= q_head.upd_time;
            crev_reg <= q_head.cmp_rev;
        end
        if (emit) begin
            kind_reg  <= sel_kind;
            rev_reg   <= sel_rev;
            otime_reg <= sel_time;
            last_reg  <= remain == '0;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_rev   = rev_reg;
    assign out_time  = otime_reg;
    assign out_last  = last_reg;

endmodule

// ===== hw/rtl/tween_phase_event_sequencer.sv =====
// Top level of the tween phase event sequencer: configuration registers, front part,
// request queue and back part. Depends on tpes_pkg, tpes_front, tpes_queue, tpes_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  new_time in tdata, reverse in tuser
//   m_        out        m_tvalid/m_tready  time_value in tdata, kind/reverse in tuser
//   cfg_      in         cfg_valid/ready    register index and write data
//
// A request is taken every cycle while the queue has room; it passes two front stages
// (subtract, then the 32 by 32 multiply) before its events are queued.
// The back part sends one event per cycle unless m_tready stalls it; a request causes zero
// to five events. The first event passes the queue and the back slot and output registers.
// Reset clears the flags, sets the last loop iteration to all ones and zeroes the registers.
// A stalled result channel fills the queue and then holds s_tready low.
module tween_phase_event_sequencer #(
    parameter int unsigned FRAC_BITS = tpes_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [31:0] new_time
    input  logic [0:0]                       s_tuser,   // [0] reverse
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [31:0] time_value
    output logic [2:0]                       m_tuser,   // [1:0] event_kind, [2] event_reverse
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tpes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);
    import tpes_pkg::*;

    cfg_t     cfg_reg;
    logic     q_push;
    q_entry_t q_in;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    q_entry_t q_head;
    ev_kind_t ev_kind;
    logic     ev_rev;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_START_TIME:   cfg_reg.start_time     <= cfg_data;
                CFG_DURATION:     cfg_reg.duration       <= cfg_data[30:0];
                CFG_INV_DURATION: cfg_reg.inv_duration   <= cfg_data;
                CFG_LOOP_MODE:    cfg_reg.loop_mode      <= cfg_data[0];
                CFG_PING_PONG:    cfg_reg.ping_pong_mode <= cfg_data[0];
                CFG_INFINITE:     cfg_reg.infinite_mode  <= cfg_data[0];
                CFG_ABSOLUTE:     cfg_reg.absolute_time  <= cfg_data[0];
                CFG_REMOVED:      cfg_reg.removed        <= cfg_data[0];
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    tpes_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_now   (s_tdata),
        .in_rev   (s_tuser[0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    tpes_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    tpes_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (ev_kind),
        .out_rev     (ev_rev),
        .out_time    (m_tdata),
        .out_last    (m_tlast)
    );

    assign m_tuser = {ev_rev, ev_kind};

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for tween_phase_event_sequencer: directed and random time steps,
// with an internal predictor of the event sequence checked against the result stream.
// Depends on tpes_pkg and the tween_phase_event_sequencer RTL.
`timescale 1ns / 100ps

module tb;
    import tpes_pkg::*;

    localparam int unsigned FRAC = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [31:0] new_time;
        logic        reverse;
    } time_step_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic        rev;
        logic [31:0] tval;
        logic        last;
    } event_rec_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    time_step_t  time_steps_q[$];
    event_rec_t  expected_events[$];
    event_rec_t  head_ev;

    cfg_t        cfg_shadow = '0;
    logic        trk_started = 1'b0;
    logic        trk_rev_started = 1'b0;
    logic        trk_complete = 1'b0;
    logic        trk_rev_complete = 1'b0;
    logic [31:0] trk_last_iter = 32'hFFFF_FFFF;

    longint      plan_start;
    longint      plan_dur;
    logic        plan_cycling;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_no = 0;
    int unsigned cycle_count = 0;
    bit          failed = 1'b0;

    tween_phase_event_sequencer #(.FRAC_BITS(FRAC)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic event_rec_t make_event(ev_kind_t kind, logic rev, logic [31:0] tval);
        event_rec_t ev;
        ev.kind = kind;
        ev.rev  = rev;
        ev.tval = tval;
        ev.last = 1'b0;
        return ev;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Works out the events one time step causes and advances the tracking flags.
    task automatic predict_events(input time_step_t step);
        longint      now_v;
        longint      st_v;
        longint      abs_v;
        longint      end_v;
        logic [63:0] abs_u;
        logic [63:0] prod;
        logic [63:0] phase;
        logic [63:0] rel;
        logic [63:0] one;
        logic [63:0] whole;
        logic [31:0] iter;
        logic [31:0] tval;
        event_rec_t  evs[$];
        one = 64'd1 << FRAC;
        if (cfg_shadow.removed) begin
            return;
        end
        now_v = longint'($signed(step.new_time));
        st_v  = longint'($signed(cfg_shadow.start_time));
        abs_v = now_v - st_v;
        end_v = st_v + longint'(cfg_shadow.duration);
        if (!trk_rev_started && step.reverse && now_v < st_v) begin
            evs.push_back(make_event(EV_UPDATE, 1'b0,
                cfg_shadow.absolute_time ? cfg_shadow.start_time : 32'd0));
            trk_rev_started = 1'b1;
            trk_started = 1'b0;
            evs.push_back(make_event(EV_START, 1'b1, 32'd0));
        end else if (now_v >= st_v) begin
            abs_u = abs_v;
            prod  = abs_u * {32'd0, cfg_shadow.inv_duration};
            phase = prod >> FRAC;
            if (cfg_shadow.ping_pong_mode) begin
                rel = phase & (2 * one - 1);
                if (rel > one) begin
                    rel = 2 * one - rel;
                end
            end else if (cfg_shadow.loop_mode) begin
                rel = phase & (one - 1);
            end else begin
                rel = (phase < one) ? phase : one;
            end
            if (!trk_started && !step.reverse) begin
                trk_started = 1'b1;
                trk_rev_started = 1'b0;
                trk_last_iter = 32'd0;
                evs.push_back(make_event(EV_LOOP, 1'b0, 32'd0));
                evs.push_back(make_event(EV_START, 1'b0, 32'd0));
            end
            if (cfg_shadow.absolute_time) begin
                tval = (abs_v > 64'sd2147483647) ? 32'h7FFF_FFFF : abs_v[31:0];
            end else if (cfg_shadow.inv_duration == 32'd0) begin
                tval = one[31:0];
            end else begin
                tval = rel[31:0];
            end
            if (cfg_shadow.loop_mode || cfg_shadow.ping_pong_mode) begin
                whole = phase >> FRAC;
                iter = (whole > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : whole[31:0];
                if (iter != trk_last_iter) begin
                    trk_last_iter = iter;
                    evs.push_back(make_event(EV_LOOP, 1'b0, 32'd0));
                end
            end
            evs.push_back(make_event(EV_UPDATE, 1'b0, tval));
        end
        if (now_v < end_v) begin
            if (!trk_rev_complete && step.reverse) begin
                trk_rev_complete = 1'b1;
                trk_complete = 1'b0;
                evs.push_back(make_event(EV_COMPLETE, 1'b1, 32'd0));
            end
        end else if (!cfg_shadow.loop_mode && !cfg_shadow.infinite_mode) begin
            if (!trk_complete && !step.reverse) begin
                trk_complete = 1'b1;
                trk_rev_complete = 1'b0;
                evs.push_back(make_event(EV_COMPLETE, 1'b0, 32'd0));
            end
        end
        if (evs.size() > 0) begin
            evs[evs.size() - 1].last = 1'b1;
        end
        foreach (evs[i]) begin
            expected_events.push_back(evs[i]);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (time_steps_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= time_steps_q[0].new_time;
                s_tuser  <= time_steps_q[0].reverse;
                void'(time_steps_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_TIME:   cfg_shadow.start_time     = cfg_data;
                    CFG_DURATION:     cfg_shadow.duration       = cfg_data[30:0];
                    CFG_INV_DURATION: cfg_shadow.inv_duration   = cfg_data;
                    CFG_LOOP_MODE:    cfg_shadow.loop_mode      = cfg_data[0];
                    CFG_PING_PONG:    cfg_shadow.ping_pong_mode = cfg_data[0];
                    CFG_INFINITE:     cfg_shadow.infinite_mode  = cfg_data[0];
                    CFG_ABSOLUTE:     cfg_shadow.absolute_time  = cfg_data[0];
                    CFG_REMOVED:      cfg_shadow.removed        = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_events({s_tdata, s_tuser[0]});
            end
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none actual kind %h rev %b time %h",
                             $time, m_tuser[1:0], m_tuser[2], m_tdata);
                    failed = 1'b1;
                end else begin
                    head_ev = expected_events.pop_front();
                    check_field("event_kind", head_ev.kind, m_tuser[1:0]);
                    check_field("event_reverse", head_ev.rev, m_tuser[2]);
                    check_field("time_value", head_ev.tval, m_tdata);
                    check_field("last", head_ev.last, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tween_phase_event_sequencer test failed");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the write is taken.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    // Single-bit registers get random upper bits, which the block must ignore.
    task automatic set_config(input logic [31:0] st, input logic [31:0] dur,
                              input logic [31:0] inv, input logic lp, input logic pp,
                              input logic inf, input logic ab, input logic rm);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_START_TIME, st);
        write_reg(CFG_DURATION, dur);
        write_reg(CFG_INV_DURATION, inv);
        write_reg(CFG_LOOP_MODE, {junk[31:1], lp});
        write_reg(CFG_PING_PONG, {junk[30:0], pp});
        write_reg(CFG_INFINITE, {junk[29:0], junk[31], inf});
        write_reg(CFG_ABSOLUTE, {junk[28:0], junk[31:30], ab});
        write_reg(CFG_REMOVED, {junk[27:0], junk[31:29], rm});
        cfg_valid <= 1'b0;
        plan_start   = longint'($signed(st));
        plan_dur     = longint'(dur[30:0]);
        plan_cycling = lp || pp;
    endtask

    task automatic push_step(input logic [31:0] t, input logic rev);
        time_steps_q.push_back({t, rev});
    endtask

    // Sets the idling for the next phase; phases rotate through the four idling styles.
    task automatic begin_phase();
        case (phase_no % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
        phase_no++;
    endtask

    task automatic wait_idle();
        while (time_steps_q.size() != 0 || s_tvalid || expected_events.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A forward run from before the start to past the end, then a reverse run back down.
    task automatic add_sweep();
        longint lo;
        longint hi;
        longint stride;
        longint t;
        int     steps;
        lo = plan_start - plan_dur - longint'($urandom_range(64));
        hi = plan_start + (plan_cycling ? 3 * plan_dur : plan_dur) + plan_dur / 2
             + longint'($urandom_range(64));
        steps  = $urandom_range(5, 10);
        stride = (hi - lo) / steps + 1;
        for (int i = 0; i <= steps; i++) begin
            push_step(clamp32(lo + i * stride + longint'($urandom_range(3))), 1'b0);
        end
        t = lo + steps * stride;
        while (t > lo - stride) begin
            push_step(clamp32(t), 1'b1);
            t = t - 2 * stride;
        end
    endtask

    task automatic add_noise();
        logic [31:0] t;
        t = $urandom;
        if ($urandom_range(1) == 1) begin
            push_step(t, t[7]);
        end else begin
            push_step(clamp32(plan_start + (t[0] ? plan_dur : 0) + longint'($signed(t[8:1]))),
                      t[9]);
        end
    endtask

    task automatic random_phase();
        logic [31:0] st;
        logic [31:0] dur;
        logic [63:0] inv;
        logic [31:0] bits;
        st = longint'($urandom_range(1 << 25)) - (1 << 24);
        case ($urandom_range(7))
            0: dur = 32'd0;
            1: dur = $urandom_range(1, 16);
            default: dur = $urandom_range(256, 1 << 22);
        endcase
        inv = (dur == 0) ? 64'd0 : (64'h1_0000_0000 / dur);
        if (inv > 64'hFFFF_FFFF) begin
            inv = 64'hFFFF_FFFF;
        end
        if ($urandom_range(7) == 0) begin
            inv = $urandom;
        end
        bits = $urandom;
        begin_phase();
        set_config(st, dur, inv[31:0], bits[0], bits[1], bits[2], bits[3],
                   $urandom_range(9) == 0);
        while (time_steps_q.size() < 22) begin
            if ($urandom_range(99) < 70) begin
                add_sweep();
            end else begin
                add_noise();
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at reset: zero start, zero length, zero reciprocal.
        begin_phase();
        push_step(32'hFFFF_FFFB, 1'b1);
        push_step(32'h8000_0000, 1'b0);
        push_step(32'h0000_0000, 1'b0);
        push_step(32'h7FFF_FFFF, 1'b1);
        push_step(32'h8000_0000, 1'b1);
        wait_idle();

        // Earliest start, full reciprocal: time since start and iteration both saturate.
        begin_phase();
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        push_step(32'h7FFF_FFFF, 1'b0);
        push_step(32'h8000_0000, 1'b0);
        push_step(32'h8000_0000, 1'b1);
        wait_idle();

        // Latest start with an end time past the 32-bit range; duration bit 31 is dropped.
        begin_phase();
        set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        push_step(32'h7FFF_FFFF, 1'b0);
        push_step(32'h8000_0000, 1'b1);
        push_step(32'h0000_0000, 1'b1);
        push_step(32'h7FFF_FFFF, 1'b1);
        wait_idle();

        // A removed item answers nothing.
        begin_phase();
        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
        push_step(32'h1234_5678, 1'b0);
        push_step(32'hEDCB_A987, 1'b1);
        wait_idle();

        // Unit ping-pong: half way up, half way down, turning point and end.
        begin_phase();
        set_config(32'd0, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_step(32'h0000_8000, 1'b0);
        push_step(32'h0001_8000, 1'b0);
        push_step(32'h0002_0000, 1'b0);
        push_step(32'h0001_0000, 1'b0);
        wait_idle();

        repeat (6) random_phase();

        if (!failed && expected_events.size() == 0) begin
            $display("tween_phase_event_sequencer test passed");
        end else begin
            $display("tween_phase_event_sequencer test failed");
        end
        $finish;
    end

endmodule
